FILE: hdl/assert_macros.svh
// Assertion macros for the positional sequence store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define PSS_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSS_ASSERT(lbl, cond)
`define PSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hdl/pss_pkg.sv
// Package for the positional sequence store: sizes, command codes and item types.
package pss_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int LW       = $clog2(CAPACITY + 1);
  localparam int VW       = 20;
  localparam int PW       = 7;
  localparam int SW       = 6;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_REMOVE  = 3'd1;
  localparam logic [2:0] CMD_MOVE    = 3'd2;
  localparam logic [2:0] CMD_REVERSE = 3'd3;
  localparam logic [2:0] CMD_ROTL    = 3'd4;
  localparam logic [2:0] CMD_ROTR    = 3'd5;
  localparam logic [2:0] CMD_DUMP    = 3'd6;
  localparam logic [2:0] CMD_UNKNOWN = 3'd7;

  typedef logic [LW:0] idx_t;

  typedef struct packed {
    logic [2:0]    cmd;
    logic [VW-1:0] item_value;
    logic [PW-1:0] first_pos;
    logic [SW-1:0] second_pos;
  } in_item_t;

  typedef struct packed {
    logic [VW-1:0] out_value;
    logic          is_empty;
    logic          error;
    logic          last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_COPY,
    ST_DRAIN,
    ST_DUMP
  } state_t;

endpackage

FILE: hdl/positional_sequence_store.sv
// Top level of the positional sequence store: command sequencer over two banked RAMs.
//
//  channel  ports                       handshake
//  input    start, busy, in_item        taken when start && !busy
//  output   out_valid, out_item         one-cycle strobe, no back-pressure
//
// Every edit except removal of the last entry copies the active bank into the
// other one, one entry per cycle, then swaps banks; rotations first find the
// shift amount in the remainder unit. A dump reads the entries out in order.
// Rejected and no-op commands answer in the next cycle.
// Results are never held off; only busy holds the sender.
// Synchronous reset empties the sequence; RAM contents are not cleared.
module positional_sequence_store
  import pss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

`include "assert_macros.svh"

  state_t        state_r, state_nxt;
  logic [2:0]    cmd_r, cmd_nxt;
  logic [VW-1:0] val_r, val_nxt;
  logic [PW-1:0] p1_r, p1_nxt;
  logic [SW-1:0] p2_r, p2_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] newlen_r, newlen_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic [LW-1:0] k_r, k_nxt;
  logic          bank_r, bank_nxt;
  logic          wr_en_r, wr_en_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          inj_r, inj_nxt;
  logic          rd_val_r, rd_val_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          st_valid_r, st_valid_nxt;
  logic          st_err_r, st_err_nxt;
  logic          st_empty_r, st_empty_nxt;

  logic          mod_start, mod_done;
  logic [LW-1:0] mod_rem;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rdata0, rdata1, rdata_act, wdata;
  logic          accept;
  idx_t          jj, src, tj, p1x, p2x, lenx;
  logic          inject;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign rdata_act = bank_r ? rdata1 : rdata0;
  assign wdata     = inj_r ? val_r : rdata_act;

  // two banks: read the active one, write the other
  pss_ram #(.W(VW), .D(CAPACITY)) u_bank0 (
    .clk   (clk),
    .we    (wr_en_r && bank_r),
    .waddr (wr_addr_r),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  pss_ram #(.W(VW), .D(CAPACITY)) u_bank1 (
    .clk   (clk),
    .we    (wr_en_r && !bank_r),
    .waddr (wr_addr_r),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  pss_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (p1_r),
    .divisor  (len_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // source entry in the old sequence for new position j
  always_comb begin
    jj     = idx_t'(j_r);
    p1x    = idx_t'(p1_r);
    p2x    = idx_t'(p2_r);
    lenx   = idx_t'(len_r);
    inject = 1'b0;
    tj     = '0;
    src    = jj;
    case (cmd_r)
      CMD_INSERT: begin
        inject = (jj == p1x);
        src    = (jj < p1x) ? jj : jj - 1'b1;
      end
      CMD_REMOVE: begin
        src = (jj < p1x) ? jj : jj + 1'b1;
      end
      CMD_MOVE: begin
        tj  = (jj < p2x) ? jj : jj - 1'b1;
        src = (jj == p2x) ? p1x : ((tj < p1x) ? tj : tj + 1'b1);
      end
      CMD_REVERSE: begin
        src = lenx - 1'b1 - jj;
      end
      CMD_ROTL, CMD_ROTR: begin
        src = jj + idx_t'(k_r);
        if (src >= lenx) begin
          src = src - lenx;
        end
      end
      default: begin
        src = jj;
      end
    endcase
  end

  // command sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    val_nxt      = val_r;
    p1_nxt       = p1_r;
    p2_nxt       = p2_r;
    len_nxt      = len_r;
    newlen_nxt   = newlen_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    bank_nxt     = bank_r;
    wr_en_nxt    = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    inj_nxt      = 1'b0;
    rd_val_nxt   = 1'b0;
    rd_last_nxt  = 1'b0;
    st_valid_nxt = 1'b0;
    st_err_nxt   = 1'b0;
    st_empty_nxt = 1'b0;
    mod_start    = 1'b0;
    rd_addr      = src[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_item.cmd;
          val_nxt    = in_item.item_value;
          p1_nxt     = in_item.first_pos;
          p2_nxt     = in_item.second_pos;
          j_nxt      = '0;
          k_nxt      = '0;
          newlen_nxt = len_r;
          case (in_item.cmd)
            CMD_INSERT: begin
              if (len_r >= LW'(CAPACITY) || idx_t'(in_item.first_pos) > idx_t'(len_r)) begin
                st_valid_nxt = 1'b1;
                st_err_nxt   = 1'b1;
              end else begin
                newlen_nxt = len_r + 1'b1;
                state_nxt  = ST_COPY;
              end
            end
            CMD_REMOVE: begin
              if (idx_t'(in_item.first_pos) >= idx_t'(len_r)) begin
                st_valid_nxt = 1'b1;
                st_err_nxt   = 1'b1;
              end else if (len_r == LW'(1)) begin
                // last entry goes: nothing to copy
                len_nxt      = '0;
                st_valid_nxt = 1'b1;
              end else begin
                newlen_nxt = len_r - 1'b1;
                state_nxt  = ST_COPY;
              end
            end
            CMD_MOVE: begin
              if (idx_t'(in_item.first_pos) >= idx_t'(len_r) ||
                  idx_t'(in_item.second_pos) >= idx_t'(len_r)) begin
                st_valid_nxt = 1'b1;
                st_err_nxt   = 1'b1;
              end else begin
                state_nxt = ST_COPY;
              end
            end
            CMD_REVERSE: begin
              if (len_r == '0) begin
                st_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_COPY;
              end
            end
            CMD_ROTL, CMD_ROTR: begin
              if (len_r == '0) begin
                st_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_MOD;
              end
            end
            CMD_DUMP: begin
              if (len_r == '0) begin
                st_valid_nxt = 1'b1;
                st_empty_nxt = 1'b1;
              end else begin
                state_nxt = ST_DUMP;
              end
            end
            default: begin
              st_valid_nxt = 1'b1;
              st_err_nxt   = 1'b1;
            end
          endcase
        end
      end
      ST_MOD: begin
        mod_start = (j_r == '0);
        j_nxt     = LW'(1);
        if (mod_done) begin
          if (cmd_r == CMD_ROTL || mod_rem == '0) begin
            k_nxt = mod_rem;
          end else begin
            k_nxt = len_r - mod_rem;
          end
          j_nxt     = '0;
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        // read old entry now, write it to the other bank next cycle
        wr_en_nxt   = 1'b1;
        wr_addr_nxt = j_r[AW-1:0];
        inj_nxt     = inject;
        j_nxt       = j_r + 1'b1;
        if (j_r == newlen_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        bank_nxt     = !bank_r;
        len_nxt      = newlen_r;
        st_valid_nxt = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_DUMP: begin
        rd_addr     = j_r[AW-1:0];
        rd_val_nxt  = 1'b1;
        rd_last_nxt = (j_r == len_r - 1'b1);
        j_nxt       = j_r + 1'b1;
        if (rd_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      bank_r     <= 1'b0;
      wr_en_r    <= 1'b0;
      rd_val_r   <= 1'b0;
      st_valid_r <= 1'b0;
      j_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      bank_r     <= bank_nxt;
      wr_en_r    <= wr_en_nxt;
      rd_val_r   <= rd_val_nxt;
      st_valid_r <= st_valid_nxt;
      j_r        <= j_nxt;
    end
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    newlen_r   <= newlen_nxt;
    k_r        <= k_nxt;
    wr_addr_r  <= wr_addr_nxt;
    inj_r      <= inj_nxt;
    rd_last_r  <= rd_last_nxt;
    st_err_r   <= st_err_nxt;
    st_empty_r <= st_empty_nxt;
  end

  // result item: dump data straight from the RAM read register
  assign out_valid          = rd_val_r || st_valid_r;
  assign out_item.out_value = rd_val_r ? rdata_act : '0;
  assign out_item.is_empty  = st_empty_r;
  assign out_item.error     = st_err_r;
  assign out_item.last      = rd_val_r ? rd_last_r : 1'b1;

  `PSS_ASSERT(a_len_bound, len_r <= LW'(CAPACITY))
  `PSS_ASSERT(a_one_source, !(rd_val_r && st_valid_r))
  `PSS_ASSERT_NEXT(a_drain_reports, state_r == ST_DRAIN, st_valid_r && !st_err_r)
  `PSS_ASSERT_NEXT(a_bad_cmd, accept && in_item.cmd == CMD_UNKNOWN, st_valid_r && st_err_r)

endmodule

FILE: hdl/pss_ram.sv
// Generic simple dual-port RAM with registered read.
module pss_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pss_rem.sv
// Iterative remainder unit: one dividend bit per cycle, restoring form.
module pss_rem
  import pss_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [LW-1:0] divisor,
  output logic          done,
  output logic [LW-1:0] rem
);

  localparam int CW = $clog2(PW + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] dvd_r, dvd_nxt;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [LW-1:0] dsr_r, dsr_nxt;
  logic [LW:0]   trial;

  // one shift-subtract step per cycle
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[PW-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CW'(PW);
      dvd_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        trial = trial - {1'b0, dsr_r};
      end
      rem_nxt = trial[LW-1:0];
      dvd_nxt = {dvd_r[PW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
